// ===== rtl/eph_pkg.sv =====
// eph_pkg: shared types, constants and the heap order function for the event heap.
// Used by eph_ctrl, eph_dp and event_priority_heap. No dependencies.
`default_nettype none

package eph_pkg;

  localparam int CAPACITY = 1024;
  localparam int ADDR_W   = 10;   // index into the heap store
  localparam int CNT_W    = 11;   // holds 0 .. CAPACITY
  localparam int KEY_W    = 32;
  localparam int ID_W     = 16;

  typedef enum logic {
    OP_INSERT  = 1'b0,
    OP_EXTRACT = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } res_status_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic             flag;
    logic [ID_W-1:0]  id;
  } entry_t;

  // read port address choice
  typedef enum logic [1:0] {
    RD_PARENT    = 2'd0,
    RD_ROOT_LAST = 2'd1,
    RD_CHILDREN  = 2'd2
  } rd_mode_t;

  // what goes into the hole at pos
  typedef enum logic [1:0] {
    WR_V = 2'd0,
    WR_A = 2'd1,
    WR_B = 2'd2
  } wr_sel_t;

  typedef enum logic [2:0] {
    POS_HOLD   = 3'd0,
    POS_COUNT  = 3'd1,
    POS_ROOT   = 3'd2,
    POS_PARENT = 3'd3,
    POS_LEFT   = 3'd4,
    POS_RIGHT  = 3'd5
  } pos_op_t;

  typedef struct packed {
    logic     load_in;
    logic     check;
    logic     ext_load;
    logic     cnt_inc;
    logic     cnt_dec;
    pos_op_t  pos_op;
    logic     rd_en;
    rd_mode_t rd_mode;
    logic     wr_en;
    wr_sel_t  wr_sel;
    logic     out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic op_extract;
    logic full;
    logic empty;
    logic at_root;
    logic up_beats;   // held entry beats its parent
    logic dn_left;    // left child wins the sift-down compare
    logic dn_right;   // right child wins the sift-down compare
  } dp_stat_t;

  // a beats b: smaller key, then flag set, then smaller id
  function automatic logic beats(input entry_t a, input entry_t b);
    logic res;
    if (a.key != b.key) begin
      res = (a.key < b.key);
    end else if (a.flag != b.flag) begin
      res = a.flag;
    end else begin
      res = (a.id < b.id);
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/eph_dp.sv =====
// eph_dp: heap store, hole-based sift registers, compare logic and result registers.
// Depends on eph_pkg; driven by commands from eph_ctrl.
`default_nettype none

module eph_dp (
  input  wire                    clk,
  input  wire                    rst_n,
  input  eph_pkg::dp_cmd_t       cmd,
  output eph_pkg::dp_stat_t      stat,
  input  wire                    in_operation,
  input  wire [31:0]             in_entry_key,
  input  wire [15:0]             in_entry_id,
  input  wire                    in_priority_flag,
  output logic [1:0]             out_result_status,
  output logic [31:0]            out_key,
  output logic [15:0]            out_id,
  output logic [10:0]            out_count
);
  import eph_pkg::*;

  entry_t mem [CAPACITY];

  entry_t            v_r, v_nxt;
  entry_t            rd_a_r, rd_b_r;
  op_t               op_r, op_nxt;
  logic [ADDR_W-1:0] pos_r, pos_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  res_status_t       res_status_r, res_status_nxt;
  logic [KEY_W-1:0]  res_key_r, res_key_nxt;
  logic [ID_W-1:0]   res_id_r, res_id_nxt;
  res_status_t       o_status_r;
  logic [KEY_W-1:0]  o_key_r;
  logic [ID_W-1:0]   o_id_r;
  logic [CNT_W-1:0]  o_cnt_r;

  logic [ADDR_W-1:0] parent_idx;
  logic [ADDR_W-1:0] pos_dec;
  logic [CNT_W:0]    left_idx, right_idx;
  logic [CNT_W-1:0]  last_idx;
  logic [ADDR_W-1:0] rd_addr_a, rd_addr_b;
  entry_t            wr_data;
  entry_t            cand;
  logic              l_ok, r_ok, sel_l;

  assign pos_dec    = pos_r - ADDR_W'(1);
  assign parent_idx = pos_dec >> 1;
  assign left_idx   = {1'b0, pos_r, 1'b1};
  assign right_idx  = left_idx + (CNT_W+1)'(1);
  assign last_idx   = cnt_r - CNT_W'(1);

  always_comb begin
    unique case (cmd.rd_mode)
      RD_ROOT_LAST: begin
        rd_addr_a = '0;
        rd_addr_b = last_idx[ADDR_W-1:0];
      end
      RD_CHILDREN: begin
        rd_addr_a = left_idx[ADDR_W-1:0];
        rd_addr_b = right_idx[ADDR_W-1:0];
      end
      default: begin
        rd_addr_a = parent_idx;
        rd_addr_b = parent_idx;
      end
    endcase
  end

  always_comb begin
    unique case (cmd.wr_sel)
      WR_A:    wr_data = rd_a_r;
      WR_B:    wr_data = rd_b_r;
      default: wr_data = v_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[pos_r] <= wr_data;
    end
    if (cmd.rd_en) begin
      rd_a_r <= mem[rd_addr_a];
      rd_b_r <= mem[rd_addr_b];
    end
  end

  // status
  assign l_ok  = left_idx < {1'b0, cnt_r};
  assign r_ok  = right_idx < {1'b0, cnt_r};
  assign sel_l = l_ok && beats(rd_a_r, v_r);
  assign cand  = sel_l ? rd_a_r : v_r;

  always_comb begin
    stat.op_extract = (op_r == OP_EXTRACT);
    stat.full       = (cnt_r == CNT_W'(CAPACITY));
    stat.empty      = (cnt_r == '0);
    stat.at_root    = (pos_r == '0);
    stat.up_beats   = beats(v_r, rd_a_r);
    stat.dn_left    = sel_l;
    stat.dn_right   = r_ok && beats(rd_b_r, cand);
  end

  always_comb begin
    op_nxt         = op_r;
    v_nxt          = v_r;
    pos_nxt        = pos_r;
    cnt_nxt        = cnt_r;
    res_status_nxt = res_status_r;
    res_key_nxt    = res_key_r;
    res_id_nxt     = res_id_r;

    if (cmd.load_in) begin
      op_nxt     = op_t'(in_operation);
      v_nxt.key  = in_entry_key;
      v_nxt.flag = in_priority_flag;
      v_nxt.id   = in_entry_id;
    end
    if (cmd.check) begin
      res_key_nxt = '0;
      res_id_nxt  = '0;
      if (op_r == OP_INSERT && stat.full) begin
        res_status_nxt = ST_FULL;
      end else if (op_r == OP_EXTRACT && stat.empty) begin
        res_status_nxt = ST_EMPTY;
      end else begin
        res_status_nxt = ST_OK;
      end
    end
    if (cmd.ext_load) begin
      res_key_nxt = rd_a_r.key;
      res_id_nxt  = rd_a_r.id;
      v_nxt       = rd_b_r;   // last entry fills the root hole
    end
    if (cmd.cnt_inc) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (cmd.cnt_dec) begin
      cnt_nxt = last_idx;
    end

    unique case (cmd.pos_op)
      POS_COUNT:  pos_nxt = cnt_r[ADDR_W-1:0];
      POS_ROOT:   pos_nxt = '0;
      POS_PARENT: pos_nxt = parent_idx;
      POS_LEFT:   pos_nxt = left_idx[ADDR_W-1:0];
      POS_RIGHT:  pos_nxt = right_idx[ADDR_W-1:0];
      default:    pos_nxt = pos_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    v_r          <= v_nxt;
    pos_r        <= pos_nxt;
    res_status_r <= res_status_nxt;
    res_key_r    <= res_key_nxt;
    res_id_r     <= res_id_nxt;
    if (cmd.out_load) begin
      o_status_r <= res_status_r;
      o_key_r    <= res_key_r;
      o_id_r     <= res_id_r;
      o_cnt_r    <= cnt_r;
    end
  end

  assign out_result_status = o_status_r;
  assign out_key           = o_key_r;
  assign out_id            = o_id_r;
  assign out_count         = o_cnt_r;

endmodule

`default_nettype wire

// ===== rtl/eph_ctrl.sv =====
// eph_ctrl: sequencer for insert (sift up) and extract (sift down), plus handshakes.
// Depends on eph_pkg; drives eph_dp through dp_cmd_t and reads dp_stat_t.
`default_nettype none

module eph_ctrl (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  wire                out_ready,
  input  eph_pkg::dp_stat_t  stat,
  output eph_pkg::dp_cmd_t   cmd
);
  import eph_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE     = 8'b0000_0001,
    S_CHECK    = 8'b0000_0010,
    S_UP_RD    = 8'b0000_0100,
    S_UP_CMP   = 8'b0000_1000,
    S_EXT_LOAD = 8'b0001_0000,
    S_DN_RD    = 8'b0010_0000,
    S_DN_CMP   = 8'b0100_0000,
    S_FIN      = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt    = state_r;
    cmd          = '0;
    cmd.pos_op   = POS_HOLD;
    cmd.rd_mode  = RD_PARENT;
    cmd.wr_sel   = WR_V;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd.check = 1'b1;
        if (!stat.op_extract) begin
          if (stat.full) begin
            state_nxt = S_FIN;
          end else begin
            cmd.cnt_inc = 1'b1;
            cmd.pos_op  = POS_COUNT;
            state_nxt   = S_UP_RD;
          end
        end else begin
          if (stat.empty) begin
            state_nxt = S_FIN;
          end else begin
            cmd.rd_en   = 1'b1;
            cmd.rd_mode = RD_ROOT_LAST;
            state_nxt   = S_EXT_LOAD;
          end
        end
      end
      S_UP_RD: begin
        if (stat.at_root) begin
          cmd.wr_en  = 1'b1;
          cmd.wr_sel = WR_V;
          state_nxt  = S_FIN;
        end else begin
          cmd.rd_en   = 1'b1;
          cmd.rd_mode = RD_PARENT;
          state_nxt   = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        cmd.wr_en = 1'b1;
        if (stat.up_beats) begin
          // parent moves down into the hole
          cmd.wr_sel = WR_A;
          cmd.pos_op = POS_PARENT;
          state_nxt  = S_UP_RD;
        end else begin
          cmd.wr_sel = WR_V;
          state_nxt  = S_FIN;
        end
      end
      S_EXT_LOAD: begin
        cmd.ext_load = 1'b1;
        cmd.cnt_dec  = 1'b1;
        cmd.pos_op   = POS_ROOT;
        state_nxt    = S_DN_RD;
      end
      S_DN_RD: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_mode = RD_CHILDREN;
        state_nxt   = S_DN_CMP;
      end
      S_DN_CMP: begin
        cmd.wr_en = 1'b1;
        if (stat.dn_right) begin
          cmd.wr_sel = WR_B;
          cmd.pos_op = POS_RIGHT;
          state_nxt  = S_DN_RD;
        end else if (stat.dn_left) begin
          cmd.wr_sel = WR_A;
          cmd.pos_op = POS_LEFT;
          state_nxt  = S_DN_RD;
        end else begin
          cmd.wr_sel = WR_V;
          state_nxt  = S_FIN;
        end
      end
      S_FIN: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_valid_nxt = cmd.out_load || (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/event_priority_heap.sv =====
// Binary min-heap of up to 1024 events, ordered by key, then priority flag set, then smaller
// id. Each item is an insert or an extract-minimum and yields one result with the status and
// the entry count after the operation. Items are handled one at a time: an insert climbs one
// tree level per read-compare pair (S_UP_RD, S_UP_CMP) and an extract descends one level per
// pair (S_DN_RD, S_DN_CMP); an insert dropped on a full heap or an extract from an empty heap
// goes straight from the check to the result. Timing is set by the heap store's single write
// port and registered reads. The heap store needs no clearing after reset; the input side is
// ready again as soon as a result sits in the output register.
// Depends on eph_pkg, eph_ctrl and eph_dp.
`default_nettype none

module event_priority_heap (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_valid,
  output logic        in_ready,
  input  wire         in_operation,
  input  wire  [31:0] in_entry_key,
  input  wire  [15:0] in_entry_id,
  input  wire         in_priority_flag,
  output logic        out_valid,
  input  wire         out_ready,
  output logic [1:0]  out_result_status,
  output logic [31:0] out_key,
  output logic [15:0] out_id,
  output logic [10:0] out_count
);
  import eph_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  eph_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  eph_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .in_operation      (in_operation),
    .in_entry_key      (in_entry_key),
    .in_entry_id       (in_entry_id),
    .in_priority_flag  (in_priority_flag),
    .out_result_status (out_result_status),
    .out_key           (out_key),
    .out_id            (out_id),
    .out_count         (out_count)
  );

endmodule

`default_nettype wire
